>>> src/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg: shared types and constants
// Widths, field codes and the walk state type of the range mapper.
// ----------------------------------------------------------------------------
package crm_pkg;

	localparam int MAP_DEPTH_DEF = 4096;
	localparam int IN_BITS_W     = 43;
	localparam int OUT_BYTES_W   = 40;
	localparam int BYTE_W        = 41;
	localparam int ENTRY_W       = IN_BITS_W + OUT_BYTES_W + 1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_OUT0,
		ST_OUT1
	} state_t;

endpackage

>>> src/crm_ram.sv
// ----------------------------------------------------------------------------
// crm_ram: generic single port ram
// One access per cycle, read data registered; a write returns the old data.
// ----------------------------------------------------------------------------
module crm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/compressed_range_mapper_unit.sv
// ----------------------------------------------------------------------------
// compressed_range_mapper_unit: byte offset to compressed offset map
// Loads running-total map entries and translates byte ranges by a table walk.
// ----------------------------------------------------------------------------
// channel | dir | word
// s_axis  | in  | load entry or query range
// m_axis  | out | compressed byte range result
// Loads can follow back to back. A query visits map entries through the
// single ram port, each entry in a read state and then a compare state,
// and ends with up to two result words; a query of a failed batch is
// dropped without a walk. Reset clears the counters and batch state; the
// map is undefined until loaded. The input stalls during a walk and while
// a result waits on m_axis.
module compressed_range_mapper_unit
	import crm_pkg::*;
#(
	parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// in_bits_delta_raw[31:0], out_bytes_delta[63:32], range_start[103:64],
	// range_end[143:104]
	input  logic [143:0] s_axis_tdata,
	// mode
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// comp_start_byte[40:0], comp_end_byte[81:41], zero to 87
	output logic [87:0]  m_axis_tdata,
	// failed
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int CW = $clog2(MAP_DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic [IN_BITS_W-1:0]   sum_in_q;
	logic [OUT_BYTES_W-1:0] sum_out_q;
	logic                   open_q, pend_v_q, failed_q;
	logic [BYTE_W-1:0]      pend_s_q, pend_e_q;
	logic [OUT_BYTES_W-1:0] rs_q, re_q;
	logic                   last_q;
	logic [CW-1:0]          j_q;
	logic [IN_BITS_W-1:0]   last_bs_q, zs_q, ze_q;
	logic                   have_s_q;
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
	logic [BYTE_W-1:0]      o_s_q, o_e_q, o1_s_q, o1_e_q;
	logic                   o_f_q, o_be_q, o1_be_q, two_q;

	// ram entry: block start, out bytes, in bits
	crm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAP_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	logic                   load_acc, query_acc;
	logic [IN_BITS_W:0]     in_add;
	logic [OUT_BYTES_W:0]   out_add;
	logic [IN_BITS_W-1:0]   base_in, new_in;
	logic [OUT_BYTES_W-1:0] base_out, new_out;
	logic [CW-1:0]          base_cnt;
	logic [IN_BITS_W-1:0]   e_ib;
	logic [OUT_BYTES_W-1:0] e_ob;
	logic                   e_bs, hit_s, hit_e, is_last_e;
	logic [BYTE_W-1:0]      ns, ne;
	logic [IN_BITS_W:0]     ze7;
	logic                   fail_now, done_now, hs_n, merge;
	logic [IN_BITS_W-1:0]   zs_n, ze_n, lbs_n;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign load_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_LOAD);
	assign query_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY);

	// saturating running sums
	always_comb begin
		base_in  = open_q ? sum_in_q : '0;
		base_out = open_q ? sum_out_q : '0;
		base_cnt = open_q ? count_q : '0;
		in_add   = {1'b0, base_in} + {{(IN_BITS_W-31+1){1'b0}}, s_axis_tdata[30:0]};
		out_add  = {1'b0, base_out} + {{(OUT_BYTES_W-32+1){1'b0}}, s_axis_tdata[63:32]};
		new_in   = in_add[IN_BITS_W] ? '1 : in_add[IN_BITS_W-1:0];
		new_out  = out_add[OUT_BYTES_W] ? '1 : out_add[OUT_BYTES_W-1:0];
	end

	// ram port: write on load while the map has room, walk address otherwise
	always_comb begin
		ram_we    = load_acc && (base_cnt < CW'(MAP_DEPTH));
		ram_wdata = {~s_axis_tdata[31], new_out, new_in};
		ram_addr  = load_acc ? base_cnt[AW-1:0] : j_q[AW-1:0];
	end

	// entry compare
	always_comb begin
		e_ib      = ram_rdata[IN_BITS_W-1:0];
		e_ob      = ram_rdata[IN_BITS_W +: OUT_BYTES_W];
		e_bs      = ram_rdata[ENTRY_W-1];
		is_last_e = (j_q == count_q - CW'(1));
		hit_s     = rs_q < e_ob;
		hit_e     = hit_s && ((re_q <= e_ob) || is_last_e);
	end

	// one walk step on entry j_q (or empty map)
	always_comb begin
		fail_now = 1'b0;
		done_now = 1'b0;
		hs_n     = have_s_q;
		zs_n     = zs_q;
		ze_n     = ze_q;
		lbs_n    = last_bs_q;
		if (count_q == '0) begin
			fail_now = 1'b1;
		end else begin
			if (hit_s && !have_s_q) begin
				if (j_q == '0) fail_now = 1'b1;
				zs_n = last_bs_q;
				hs_n = 1'b1;
			end
			if (e_bs) lbs_n = e_ib;
			if (hit_e && !fail_now) begin
				ze_n     = e_ib;
				done_now = 1'b1;
			end
			if (!done_now && !fail_now && is_last_e) fail_now = 1'b1;
		end
		ze7   = {1'b0, ze_n} + (IN_BITS_W+1)'(7);
		ns    = BYTE_W'(zs_n >> 3);
		ne    = BYTE_W'(ze7 >> 3);
		merge = pend_v_q && (pend_e_q >= ns);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc && !failed_q) state_d = ST_READ;
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (fail_now) begin
					state_d = ST_OUT0;
				end else if (done_now) begin
					state_d = ((pend_v_q && !merge) || last_q) ? ST_OUT0 : ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_OUT0: if (m_axis_tready) state_d = two_q ? ST_OUT1 : ST_IDLE;
			ST_OUT1: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		m_axis_tvalid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		m_axis_tdata  = '0;
		m_axis_tuser  = 1'b0;
		m_axis_tlast  = 1'b0;
		if (state_q == ST_OUT1) begin
			m_axis_tdata[81:0] = {o1_e_q, o1_s_q};
			m_axis_tlast       = o1_be_q;
		end else begin
			m_axis_tdata[81:0] = {o_e_q, o_s_q};
			m_axis_tuser       = o_f_q;
			m_axis_tlast       = o_be_q;
		end
	end

	// control and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			sum_in_q  <= '0;
			sum_out_q <= '0;
			open_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_s_q  <= '0;
			pend_e_q  <= '0;
			failed_q  <= 1'b0;
			j_q       <= '0;
			have_s_q  <= 1'b0;
			two_q     <= 1'b0;
			last_bs_q <= '0;
			zs_q      <= '0;
			ze_q      <= '0;
			o_s_q     <= '0;
			o_e_q     <= '0;
			o_f_q     <= 1'b0;
			o_be_q    <= 1'b0;
			o1_s_q    <= '0;
			o1_e_q    <= '0;
			o1_be_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						sum_in_q  <= new_in;
						sum_out_q <= new_out;
						count_q   <= (base_cnt < CW'(MAP_DEPTH)) ? base_cnt + CW'(1) : base_cnt;
						open_q    <= !s_axis_tlast;
					end
					if (query_acc) begin
						if (failed_q) begin
							if (s_axis_tlast) failed_q <= 1'b0;
						end else begin
							j_q       <= '0;
							have_s_q  <= 1'b0;
							last_bs_q <= '0;
							zs_q      <= '0;
							ze_q      <= '0;
						end
					end
				end
				ST_READ: begin
					// address j_q presented; data next cycle
				end
				ST_CHECK: begin
					zs_q      <= zs_n;
					ze_q      <= ze_n;
					last_bs_q <= lbs_n;
					have_s_q  <= hs_n;
					if (fail_now) begin
						pend_v_q <= 1'b0;
						pend_s_q <= '0;
						pend_e_q <= '0;
						failed_q <= !last_q;
						o_s_q <= '0; o_e_q <= '0; o_f_q <= 1'b1; o_be_q <= 1'b1;
						two_q <= 1'b0;
					end else if (done_now) begin
						if (merge) begin
							if (last_q) begin
								o_s_q <= pend_s_q; o_e_q <= ne; o_f_q <= 1'b0;
								o_be_q <= 1'b1; two_q <= 1'b0;
								pend_v_q <= 1'b0; pend_s_q <= '0; pend_e_q <= '0;
							end else begin
								pend_e_q <= ne;
							end
						end else if (pend_v_q) begin
							o_s_q <= pend_s_q; o_e_q <= pend_e_q; o_f_q <= 1'b0;
							o_be_q <= 1'b0;
							o1_s_q <= ns; o1_e_q <= ne; o1_be_q <= 1'b1;
							two_q <= last_q;
							if (last_q) begin
								pend_v_q <= 1'b0; pend_s_q <= '0; pend_e_q <= '0;
							end else begin
								pend_s_q <= ns; pend_e_q <= ne;
							end
						end else if (last_q) begin
							o_s_q <= ns; o_e_q <= ne; o_f_q <= 1'b0; o_be_q <= 1'b1;
							two_q <= 1'b0;
							pend_v_q <= 1'b0; pend_s_q <= '0; pend_e_q <= '0;
						end else begin
							pend_v_q <= 1'b1; pend_s_q <= ns; pend_e_q <= ne;
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// query capture
	always_ff @(posedge clk) begin
		if (query_acc) begin
			rs_q   <= s_axis_tdata[103:64];
			re_q   <= s_axis_tdata[143:104];
			last_q <= s_axis_tlast;
		end
	end

endmodule
